>>> rtl/sb512_pkg.sv
// Package for the Streebog-512 hash block: S-box, linear-map rows, round constants.
// Used by streebog_512_hash_top and sb512_lps. No dependencies.
`default_nettype none
package sb512_pkg;

  localparam int unsigned WordW   = 64;
  localparam int unsigned Words   = 8;
  localparam int unsigned Rounds  = 12;

  typedef logic [WordW-1:0] word_t;
  typedef word_t [Words-1:0] blk_t;

  localparam logic [7:0] SBOX [256] = '{
    8'd252,8'd238,8'd221,8'd17,8'd207,8'd110,8'd49,8'd22,8'd251,8'd196,8'd250,8'd218,8'd35,8'd197,8'd4,8'd77,
    8'd233,8'd119,8'd240,8'd219,8'd147,8'd46,8'd153,8'd186,8'd23,8'd54,8'd241,8'd187,8'd20,8'd205,8'd95,8'd193,
    8'd249,8'd24,8'd101,8'd90,8'd226,8'd92,8'd239,8'd33,8'd129,8'd28,8'd60,8'd66,8'd139,8'd1,8'd142,8'd79,
    8'd5,8'd132,8'd2,8'd174,8'd227,8'd106,8'd143,8'd160,8'd6,8'd11,8'd237,8'd152,8'd127,8'd212,8'd211,8'd31,
    8'd235,8'd52,8'd44,8'd81,8'd234,8'd200,8'd72,8'd171,8'd242,8'd42,8'd104,8'd162,8'd253,8'd58,8'd206,8'd204,
    8'd181,8'd112,8'd14,8'd86,8'd8,8'd12,8'd118,8'd18,8'd191,8'd114,8'd19,8'd71,8'd156,8'd183,8'd93,8'd135,
    8'd21,8'd161,8'd150,8'd41,8'd16,8'd123,8'd154,8'd199,8'd243,8'd145,8'd120,8'd111,8'd157,8'd158,8'd178,8'd177,
    8'd50,8'd117,8'd25,8'd61,8'd255,8'd53,8'd138,8'd126,8'd109,8'd84,8'd198,8'd128,8'd195,8'd189,8'd13,8'd87,
    8'd223,8'd245,8'd36,8'd169,8'd62,8'd168,8'd67,8'd201,8'd215,8'd121,8'd214,8'd246,8'd124,8'd34,8'd185,8'd3,
    8'd224,8'd15,8'd236,8'd222,8'd122,8'd148,8'd176,8'd188,8'd220,8'd232,8'd40,8'd80,8'd78,8'd51,8'd10,8'd74,
    8'd167,8'd151,8'd96,8'd115,8'd30,8'd0,8'd98,8'd68,8'd26,8'd184,8'd56,8'd130,8'd100,8'd159,8'd38,8'd65,
    8'd173,8'd69,8'd70,8'd146,8'd39,8'd94,8'd85,8'd47,8'd140,8'd163,8'd165,8'd125,8'd105,8'd213,8'd149,8'd59,
    8'd7,8'd88,8'd179,8'd64,8'd134,8'd172,8'd29,8'd247,8'd48,8'd55,8'd107,8'd228,8'd136,8'd217,8'd231,8'd137,
    8'd225,8'd27,8'd131,8'd73,8'd76,8'd63,8'd248,8'd254,8'd141,8'd83,8'd170,8'd144,8'd202,8'd216,8'd133,8'd97,
    8'd32,8'd113,8'd103,8'd164,8'd45,8'd43,8'd9,8'd91,8'd203,8'd155,8'd37,8'd208,8'd190,8'd229,8'd108,8'd82,
    8'd89,8'd166,8'd116,8'd210,8'd230,8'd244,8'd180,8'd192,8'd209,8'd102,8'd175,8'd194,8'd57,8'd75,8'd99,8'd182
  };

  // Row i is selected by bit (63 - i) of a word.
  localparam word_t LIN_ROWS [64] = '{
    64'h8e20faa72ba0b470, 64'h47107ddd9b505a38, 64'had08b0e0c3282d1c, 64'hd8045870ef14980e,
    64'h6c022c38f90a4c07, 64'h3601161cf205268d, 64'h1b8e0b0e798c13c8, 64'h83478b07b2468764,
    64'ha011d380818e8f40, 64'h5086e740ce47c920, 64'h2843fd2067adea10, 64'h14aff010bdd87508,
    64'h0ad97808d06cb404, 64'h05e23c0468365a02, 64'h8c711e02341b2d01, 64'h46b60f011a83988e,
    64'h90dab52a387ae76f, 64'h486dd4151c3dfdb9, 64'h24b86a840e90f0d2, 64'h125c354207487869,
    64'h092e94218d243cba, 64'h8a174a9ec8121e5d, 64'h4585254f64090fa0, 64'haccc9ca9328a8950,
    64'h9d4df05d5f661451, 64'hc0a878a0a1330aa6, 64'h60543c50de970553, 64'h302a1e286fc58ca7,
    64'h18150f14b9ec46dd, 64'h0c84890ad27623e0, 64'h0642ca05693b9f70, 64'h0321658cba93c138,
    64'h86275df09ce8aaa8, 64'h439da0784e745554, 64'hafc0503c273aa42a, 64'hd960281e9d1d5215,
    64'he230140fc0802984, 64'h71180a8960409a42, 64'hb60c05ca30204d21, 64'h5b068c651810a89e,
    64'h456c34887a3805b9, 64'hac361a443d1c8cd2, 64'h561b0d22900e4669, 64'h2b838811480723ba,
    64'h9bcf4486248d9f5d, 64'hc3e9224312c8c1a0, 64'heffa11af0964ee50, 64'hf97d86d98a327728,
    64'he4fa2054a80b329c, 64'h727d102a548b194e, 64'h39b008152acb8227, 64'h9258048415eb419d,
    64'h492c024284fbaec0, 64'haa16012142f35760, 64'h550b8e9e21f7a530, 64'ha48b474f9ef5dc18,
    64'h70a6a56e2440598e, 64'h3853dc371220a247, 64'h1ca76e95091051ad, 64'h0edd37c48a08a6d8,
    64'h07e095624504536c, 64'h8d70c431ac02a736, 64'hc83862965601dd1b, 64'h641c314b2b8ee083
  };

  localparam blk_t ROUND_C [Rounds] = '{
    '{64'hb1085bda1ecadae9,64'hebcb2f81c0657c1f,64'h2f6a76432e45d016,64'h714eb88d7585c4fc,
      64'h4b7ce09192676901,64'ha2422a08a460d315,64'h05767436cc744d23,64'hdd806559f2a64507},
    '{64'h6fa3b58aa99d2f1a,64'h4fe39d460f70b5d7,64'hf3feea720a232b98,64'h61d55e0f16b50131,
      64'h9ab5176b12d69958,64'h5cb561c2db0aa7ca,64'h55dda21bd7cbcd56,64'he679047021b19bb7},
    '{64'hf574dcac2bce2fc7,64'h0a39fc286a3d8435,64'h06f15e5f529c1f8b,64'hf2ea7514b1297b7b,
      64'hd3e20fe490359eb1,64'hc1c93a376062db09,64'hc2b6f443867adb31,64'h991e96f50aba0ab2},
    '{64'hef1fdfb3e81566d2,64'hf948e1a05d71e4dd,64'h488e857e335c3c7d,64'h9d721cad685e353f,
      64'ha9d72c82ed03d675,64'hd8b71333935203be,64'h3453eaa193e837f1,64'h220cbebc84e3d12e},
    '{64'h4bea6bacad474799,64'h9a3f410c6ca92363,64'h7f151c1f1686104a,64'h359e35d7800fffbd,
      64'hbfcd1747253af5a3,64'hdfff00b723271a16,64'h7a56a27ea9ea63f5,64'h601758fd7c6cfe57},
    '{64'hae4faeae1d3ad3d9,64'h6fa4c33b7a3039c0,64'h2d66c4f95142a46c,64'h187f9ab49af08ec6,
      64'hcffaa6b71c9ab7b4,64'h0af21f66c2bec6b6,64'hbf71c57236904f35,64'hfa68407a46647d6e},
    '{64'hf4c70e16eeaac5ec,64'h51ac86febf240954,64'h399ec6c7e6bf87c9,64'hd3473e33197a93c9,
      64'h0992abc52d822c37,64'h06476983284a0504,64'h3517454ca23c4af3,64'h8886564d3a14d493},
    '{64'h9b1f5b424d93c9a7,64'h03e7aa020c6e4141,64'h4eb7f8719c36de1e,64'h89b4443b4ddbc49a,
      64'hf4892bcb929b0690,64'h69d18d2bd1a5c42f,64'h36acc2355951a8d9,64'ha47f0dd4bf02e71e},
    '{64'h378f5a541631229b,64'h944c9ad8ec165fde,64'h3a7d3a1b25894224,64'h3cd955b7e00d0984,
      64'h800a440bdbb2ceb1,64'h7b2b8a9aa6079c54,64'h0e38dc92cb1f2a60,64'h7261445183235adb},
    '{64'habbedea680056f52,64'h382ae548b2e4f3f3,64'h8941e71cff8a78db,64'h1fffe18a1b336103,
      64'h9fe76702af69334b,64'h7a1e6c303b7652f4,64'h3698fad1153bb6c3,64'h74b4c7fb98459ced},
    '{64'h7bcd9ed0efc889fb,64'h3002c6cd635afe94,64'hd8fa6bbbebab0761,64'h2001802114846679,
      64'h8a1d71efea48b9ca,64'hefbacd1d7d476e98,64'hdea2594ac06fd85d,64'h6bcaa4cd81f32d1b},
    '{64'h378ee767f11631ba,64'hd21380b00449b17a,64'hcda43c32bcdf1d77,64'hf82012d430219f9b,
      64'h5d80ef9d1891cc86,64'he71da4aa88e12852,64'hfaf417d5d9b21b99,64'h48bc924af11bd720}
  };

  // Linear map of one 64-bit word: XOR of the rows its set bits select.
  function automatic word_t lin_map(input word_t t);
    word_t acc;
    acc = '0;
    for (int j = 0; j < 64; j++) begin
      if (t[j]) begin
        acc = acc ^ LIN_ROWS[63-j];
      end
    end
    return acc;
  endfunction

endpackage
`default_nettype wire

>>> rtl/sb512_lps.sv
// One LPS transform of a 512-bit block, applied to the XOR of two operands.
// Depends on sb512_pkg for the S-box and linear map.
`default_nettype none
module sb512_lps import sb512_pkg::*; (
  input  wire blk_t a,
  input  wire blk_t b,
  output blk_t      y
);

  blk_t x;
  blk_t t;

  always_comb begin
    for (int r = 0; r < 8; r++) begin
      x[r] = a[r] ^ b[r];
    end
    for (int r = 0; r < 8; r++) begin
      for (int c = 0; c < 8; c++) begin
        t[r][8*c +: 8] = SBOX[x[c][8*r +: 8]];
      end
    end
    for (int r = 0; r < 8; r++) begin
      y[r] = lin_map(t[r]);
    end
  end

endmodule
`default_nettype wire

>>> rtl/streebog_512_hash_top.sv
// Streebog-512 hash top level: word gathering, padding, shared LPS unit, digest output.
// Depends on sb512_pkg and sb512_lps.
// A word's valid bytes are gathered into the block byte by byte before the next word is taken.
// A block that fills adds one compression (one LPS per cycle) and the lane-by-lane
// counter and checksum sums; a final word then adds a pad, three compressions and one sum
// pass before the eight digest words, which wait on m_tready.
// A new word is taken only once the block is idle again, so messages never overlap.
// Reset: rst is synchronous, active high, and clears chain value, counter, checksum and fill.
`default_nettype none
module streebog_512_hash_top import sb512_pkg::*; (
  input  wire        clk,
  input  wire        rst,
  input  wire        s_tvalid,
  output logic       s_tready,
  input  wire [71:0] s_tdata,   // data_word[63:0], valid_bytes[67:64], zero fill [71:68]
  input  wire        s_tlast,   // last
  output logic       m_tvalid,
  input  wire        m_tready,
  output logic [71:0] m_tdata,  // digest_word[63:0], word_index[66:64], zero fill [71:67]
  output logic       m_tlast    // digest_last
);

  // Sequencer states. GATHER places one byte of the held word into the block each cycle,
  // at most eight per word. COMP runs one compression; SUM updates counter and checksum
  // one 64-bit lane per cycle after a block.
  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_GATHER = 7'b0000010,
    S_COMP   = 7'b0000100,
    S_SUM    = 7'b0001000,
    S_PAD    = 7'b0010000,
    S_FIN    = 7'b0100000,
    S_OUT    = 7'b1000000
  } state_t;

  // Which compression is running: a data block, the padded final block, g0 with N, g0 with sum.
  typedef enum logic [1:0] {
    C_BLOCK = 2'd0,
    C_PAD   = 2'd1,
    C_LEN   = 2'd2,
    C_SUM   = 2'd3
  } comp_t;

  state_t     state;
  comp_t      comp;
  blk_t       chain_value, length_counter, checksum_sum, block_buffer;
  blk_t       key, ebuf, msg, nkey;
  logic [5:0] byte_fill;
  logic [4:0] step;           // LPS step 0..24 of a compression
  logic [63:0] data_hold;
  logic [3:0] bytes_left;
  logic       last_hold;
  logic [2:0] out_idx;
  logic [2:0] sum_lane;       // lane of the counter and checksum sums
  logic       cy_len, cy_sum; // carries into the current lane

  blk_t lps_a, lps_b, lps_y;

  sb512_lps u_lps (.a(lps_a), .b(lps_b), .y(lps_y));

  // Step 0: K = LPS(h ^ N). Step 1: E = LPS(K ^ m). Then even steps update K with a round
  // constant, odd steps update E; step 24 is the last key update.
  logic [3:0] rnd;
  assign rnd = 4'((step - 5'd2) >> 1);

  always_comb begin
    lps_a = key;
    lps_b = ebuf;
    if (step == 5'd0) begin
      lps_a = chain_value;
      lps_b = nkey;
    end else if (step == 5'd1) begin
      lps_a = key;
      lps_b = msg;
    end else if (!step[0]) begin
      lps_a = key;
      lps_b = ROUND_C[rnd];
    end
  end

  always_comb begin
    unique case (comp)
      C_BLOCK, C_PAD: begin
        msg  = block_buffer;
        nkey = length_counter;
      end
      C_LEN: begin
        msg  = length_counter;
        nkey = '0;
      end
      C_SUM: begin
        msg  = checksum_sum;
        nkey = '0;
      end
      default: begin
        msg  = block_buffer;
        nkey = length_counter;
      end
    endcase
  end

  logic [3:0] cnt_in;
  assign cnt_in = (s_tdata[67:64] > 4'd8) ? 4'd8 : s_tdata[67:64];

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_OUT);
  assign m_tdata  = {5'd0, out_idx, chain_value[out_idx]};
  assign m_tlast  = (out_idx == 3'd7);

  blk_t len_add;
  always_comb begin
    len_add = '0;
    if (comp == C_PAD) begin
      len_add[0] = {55'd0, byte_fill, 3'd0};
    end else begin
      len_add[0] = 64'd512;
    end
  end

  // One 64-bit lane of each 512-bit sum per cycle, the carry held between lanes.
  logic [64:0] len_lane, chk_lane;
  assign len_lane = {1'b0, length_counter[sum_lane]} + {1'b0, len_add[sum_lane]}
                    + {64'd0, cy_len};
  assign chk_lane = {1'b0, checksum_sum[sum_lane]} + {1'b0, block_buffer[sum_lane]}
                    + {64'd0, cy_sum};

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      comp           <= C_BLOCK;
      chain_value    <= '0;
      length_counter <= '0;
      checksum_sum   <= '0;
      byte_fill      <= '0;
      step           <= '0;
      out_idx        <= '0;
      bytes_left     <= '0;
      last_hold      <= 1'b0;
      sum_lane       <= '0;
      cy_len         <= 1'b0;
      cy_sum         <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            data_hold  <= s_tdata[63:0];
            bytes_left <= cnt_in;
            last_hold  <= s_tlast;
            state      <= S_GATHER;
          end
        end
        S_GATHER: begin
          if (bytes_left != 4'd0) begin
            block_buffer[byte_fill[5:3]][8*byte_fill[2:0] +: 8] <= data_hold[7:0];
            data_hold  <= data_hold >> 8;
            bytes_left <= bytes_left - 4'd1;
            byte_fill  <= byte_fill + 6'd1;
            if (byte_fill == 6'd63) begin
              comp  <= C_BLOCK;
              step  <= '0;
              state <= S_COMP;
            end
          end else if (last_hold) begin
            state <= S_PAD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_PAD: begin
          // Pad byte 0x01 at the fill point, zeros above it.
          for (int i = 0; i < 64; i++) begin
            if (6'(i) == byte_fill) begin
              block_buffer[i/8][8*(i%8) +: 8] <= 8'h01;
            end else if (6'(i) > byte_fill) begin
              block_buffer[i/8][8*(i%8) +: 8] <= 8'h00;
            end
          end
          comp  <= C_PAD;
          step  <= '0;
          state <= S_COMP;
        end
        S_COMP: begin
          if (step == 5'd0 || step[0] == 1'b0) begin
            key <= lps_y;
          end else begin
            ebuf <= lps_y;
          end
          if (step == 5'd24) begin
            // final step: key update folded into the chain value below
            unique case (comp)
              C_BLOCK, C_PAD: state <= S_SUM;
              C_LEN: begin
                comp  <= C_SUM;
                state <= S_COMP;
              end
              C_SUM: begin
                out_idx <= '0;
                state   <= S_OUT;
              end
              default: state <= S_IDLE;
            endcase
            chain_value <= chain_value ^ ebuf ^ lps_y ^ msg;
            step <= '0;
          end else begin
            step <= step + 5'd1;
          end
        end
        S_SUM: begin
          length_counter[sum_lane] <= len_lane[63:0];
          checksum_sum[sum_lane]   <= chk_lane[63:0];
          sum_lane <= sum_lane + 3'd1;
          cy_len   <= (sum_lane == 3'd7) ? 1'b0 : len_lane[64];
          cy_sum   <= (sum_lane == 3'd7) ? 1'b0 : chk_lane[64];
          if (sum_lane == 3'd7) begin
            byte_fill <= '0;
            if (comp == C_PAD) begin
              comp  <= C_LEN;
              step  <= '0;
              state <= S_COMP;
            end else begin
              state <= S_GATHER;
            end
          end
        end
        S_OUT: begin
          if (m_tready) begin
            out_idx <= out_idx + 3'd1;
            if (out_idx == 3'd7) begin
              chain_value    <= '0;
              length_counter <= '0;
              checksum_sum   <= '0;
              byte_fill      <= '0;
              state          <= S_IDLE;
            end
          end
        end
        S_FIN: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // Input is taken only when the sequencer is idle.
  assert property (@(posedge clk) disable iff (rst) (s_tvalid && s_tready) |=> state == S_GATHER)
    else $error("accepted word did not start gathering");
  // Digest words only leave while nothing is being accepted.
  assert property (@(posedge clk) disable iff (rst) !(m_tvalid && s_tready))
    else $error("output and input sides active together");
  // The LPS step counter never passes the last key update.
  assert property (@(posedge clk) disable iff (rst) step <= 5'd24)
    else $error("LPS step out of range");
  // After the eighth digest word the block returns to idle.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> state == S_IDLE)
    else $error("digest did not end cleanly");

endmodule
`default_nettype wire

>>> sim/sb512_checker.sv
// Checker for the Streebog-512 hash block: watches both streams, predicts the digest
// words in its own model of the hash and compares them. Depends on sb512_pkg.
module sb512_checker import sb512_pkg::*; (
  input  wire        clk,
  input  wire        rst,
  input  wire        s_tvalid,
  input  wire        s_tready,
  input  wire [71:0] s_tdata,
  input  wire        s_tlast,
  input  wire        m_tvalid,
  input  wire        m_tready,
  input  wire [71:0] m_tdata,
  input  wire        m_tlast,
  output int         errors,
  output int         pending,
  output int         digests_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    word_t      dword;
    logic [2:0] idx;
    logic       dlast;
  } digest_beat_t;

  blk_t        hval, nlen, csum, gbuf;
  int unsigned fill;
  digest_beat_t digest_q[$];

  function automatic blk_t lps(input blk_t a, input blk_t b);
    blk_t x, t, r;
    for (int i = 0; i < 8; i++) begin
      x[i] = a[i] ^ b[i];
      t[i] = '0;
    end
    for (int i = 0; i < 8; i++) begin
      for (int c = 0; c < 8; c++) begin
        t[i][8*c +: 8] = SBOX[x[c][8*i +: 8]];
      end
    end
    for (int i = 0; i < 8; i++) begin
      r[i] = '0;
      for (int j = 0; j < 64; j++) begin
        if (t[i][j]) r[i] = r[i] ^ LIN_ROWS[63-j];
      end
    end
    return r;
  endfunction

  function automatic blk_t gn(input blk_t h, input blk_t n, input blk_t m);
    blk_t k, e, rc;
    k = lps(h, n);
    e = lps(k, m);
    for (int r = 0; r < 12; r++) begin
      // Package round constants hold word 0 at index 0.
      rc = ROUND_C[r];
      k = lps(k, rc);
      if (r < 11) e = lps(k, e);
    end
    for (int i = 0; i < 8; i++) h[i] = h[i] ^ e[i] ^ k[i] ^ m[i];
    return h;
  endfunction

  function automatic blk_t add512(input blk_t a, input blk_t b);
    logic [64:0] s;
    logic        cy;
    cy = 1'b0;
    for (int i = 0; i < 8; i++) begin
      s = {1'b0, a[i]} + {1'b0, b[i]} + {64'd0, cy};
      a[i] = s[63:0];
      cy = s[64];
    end
    return a;
  endfunction

  task automatic hash_clear();
    hval = '0;
    nlen = '0;
    csum = '0;
    gbuf = '0;
    fill = 0;
  endtask

  task automatic absorb_word(input logic [71:0] d, input logic fin);
    int unsigned cnt;
    blk_t        bits, zero;
    digest_beat_t b;
    zero = '0;
    cnt = (d[67:64] > 4'd8) ? 8 : int'(d[67:64]);
    for (int i = 0; i < cnt; i++) begin
      gbuf[fill/8][8*(fill%8) +: 8] = d[8*i +: 8];
      fill++;
      if (fill == 64) begin
        bits = '0;
        bits[0] = 64'd512;
        hval = gn(hval, nlen, gbuf);
        nlen = add512(nlen, bits);
        csum = add512(csum, gbuf);
        fill = 0;
      end
    end
    if (fin) begin
      bits = '0;
      bits[0] = 64'(fill * 8);
      gbuf[fill/8][8*(fill%8) +: 8] = 8'h01;
      for (int i = fill + 1; i < 64; i++) gbuf[i/8][8*(i%8) +: 8] = 8'h00;
      hval = gn(hval, nlen, gbuf);
      nlen = add512(nlen, bits);
      csum = add512(csum, gbuf);
      hval = gn(hval, zero, nlen);
      hval = gn(hval, zero, csum);
      for (int i = 0; i < 8; i++) begin
        b.dword = hval[i];
        b.idx   = i[2:0];
        b.dlast = (i == 7);
        digest_q.push_back(b);
      end
      hash_clear();
    end
  endtask

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  initial begin
    errors = 0;
    pending = 0;
    digests_seen = 0;
    hash_clear();
  end

  always @(posedge clk) begin
    digest_beat_t w;
    if (rst) begin
      hash_clear();
      digest_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (digest_q.size() == 0) begin
          report("unexpected digest word", m_tdata[63:0], '0);
        end else begin
          w = digest_q.pop_front();
          if (m_tdata[63:0] !== w.dword) report("digest_word", m_tdata[63:0], w.dword);
          if (m_tdata[66:64] !== w.idx) report("word_index", 64'(m_tdata[66:64]), 64'(w.idx));
          if (m_tdata[71:67] !== '0) report("tdata fill", 64'(m_tdata[71:67]), '0);
          if (m_tlast !== w.dlast) report("digest_last", 64'(m_tlast), 64'(w.dlast));
          if (w.dlast) digests_seen++;
        end
      end
      if (s_tvalid && s_tready) absorb_word(s_tdata, s_tlast);
    end
    pending = digest_q.size();
  end
endmodule

>>> sim/tb_top.sv
// Top of the Streebog-512 hash testbench: clock, reset, word stimulus and verdict.
// Depends on sb512_pkg, streebog_512_hash_top and sb512_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic [71:0] s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tready = 1'b0;
  wire         s_tready;
  wire         m_tvalid;
  wire  [71:0] m_tdata;
  wire         m_tlast;
  int          errors, pending, digests_seen;
  int          words_sent = 0;
  bit          hold_off = 1'b0;  // stimulus asks the receiver to stall for a long stretch
  bit          hold_done = 1'b0;

  always #6 clk = ~clk;

  streebog_512_hash_top DUT (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tlast,
    .m_tvalid, .m_tready, .m_tdata, .m_tlast
  );

  sb512_checker u_checker (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tlast,
    .m_tvalid, .m_tready, .m_tdata, .m_tlast,
    .errors, .pending, .digests_seen
  );

  // Drives one word and waits for its handshake. The burst counter decides whether a
  // gap of idle cycles follows, so gaps land at every point of the block's work.
  int burst_left = 0;
  task automatic send_word(input logic [63:0] d, input logic [3:0] cnt, input logic fin);
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, cnt, d};
    s_tlast  <= fin;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    words_sent++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      s_tvalid <= 1'b0;
      repeat ($urandom_range(0, 5)) @(posedge clk);
    end else begin
      burst_left--;
    end
  endtask

  // A message of n whole words, with a chosen count on the final word. Random content.
  task automatic send_message(input int n, input logic [3:0] last_cnt);
    for (int i = 0; i < n; i++) send_word({$urandom, $urandom}, 4'd8, 1'b0);
    send_word({$urandom, $urandom}, last_cnt, 1'b1);
  endtask

  // Waits until every predicted digest word has been taken.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Receiver: a stall pattern of its own, with calm stretches of constant readiness,
  // and one long hold-off that the stimulus requests.
  initial begin
    int mode;
    @(negedge rst);
    forever begin
      if (hold_off && !hold_done) begin
        m_tready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_done = 1'b1;
      end
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(4, 30)) begin
        m_tready <= (mode == 0) ? 1'b1 : ($urandom_range(0, 3) != 0);
        @(posedge clk);
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: empty message, extreme data, counts above eight, straddling short
    // words, an exact block multiple and a final word carrying no bytes.
    send_word('0, 4'd0, 1'b1);
    send_word('1, 4'd8, 1'b1);
    send_word('0, 4'd8, 1'b0);
    send_word('1, 4'd15, 1'b1);
    send_word(64'h0123456789abcdef, 4'd9, 1'b0);
    send_word(64'hfedcba9876543210, 4'd3, 1'b0);
    for (int i = 0; i < 8; i++) send_word({$urandom, $urandom}, 4'd5, 1'b0);
    send_word('1, 4'd1, 1'b1);
    send_message(7, 4'd8);         // exactly one block
    send_word('0, 4'd0, 1'b1);
    send_message(7, 4'd8);         // exactly one block again
    drain();

    // Long receiver hold-off while a digest waits: the following messages stall at the input.
    hold_off = 1'b1;
    for (int k = 0; k < 4; k++) send_message(1, 4'd4);
    while (!hold_done) @(posedge clk);
    drain();

    // Random messages: mostly short, now and then a few blocks long, with random
    // final counts and odd short words in the middle.
    while (words_sent < 180) begin
      int n;
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 6);
      for (int i = 0; i < n; i++) begin
        send_word({$urandom, $urandom},
                  ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15)) : 4'd8, 1'b0);
      end
      send_word({$urandom, $urandom}, 4'($urandom_range(0, 15)), 1'b1);
      if ($urandom_range(0, 9) == 0) drain();
    end
    drain();
    repeat (200) @(posedge clk);

    $display("Ran %0d words into %0d digests: empty, short, straddling and exact-block",
             words_sent, digests_seen);
    $display("messages, counts above eight, and receiver stalls including a long hold-off.");
    if (errors == 0 && pending == 0) begin
      $display("streebog_512_hash_top verification clean");
    end else begin
      $display("streebog_512_hash_top verification failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("streebog_512_hash_top verification failed");
    $finish;
  end
endmodule

>>> filelist.f
rtl/sb512_pkg.sv
rtl/sb512_lps.sv
rtl/streebog_512_hash_top.sv
sim/sb512_checker.sv
sim/tb_top.sv
